// ----- design/ccx_pkg.sv -----
package ccx_pkg;

    localparam int WORD_W          = 32;
    localparam int BLOCK_WORDS     = 16;
    localparam int POS_W           = 4;
    localparam int CFG_REGS        = 8;
    localparam int CFG_W           = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int ADDR_W          = 6;
    localparam int CTR_REG_IDX     = 6;
    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int QUEUE_DEPTH_DEF   = 4;

    typedef logic [CFG_REGS-1:0][CFG_W-1:0]     ccx_cfg_t;
    typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] ccx_state_t;

    // one queued word with its restart flag
    typedef struct packed {
        logic              restart;
        logic [WORD_W-1:0] data;
    } ccx_item_t;

    // request from the sequencer to the round unit
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] ctr;
    } ccx_blk_ctl_t;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } ccx_qr_t;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    function automatic ccx_qr_t quarter_round(input ccx_qr_t x);
        ccx_qr_t y;
        y = x;
        y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 16);
        y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 12);
        y.a = y.a + y.b; y.d = rotl(y.d ^ y.a, 8);
        y.c = y.c + y.d; y.b = rotl(y.b ^ y.c, 7);
        return y;
    endfunction

    // initial state: register halves, word 12 from the running counter
    function automatic ccx_state_t build_state(input ccx_cfg_t cfg,
                                               input logic [WORD_W-1:0] ctr);
        ccx_state_t s;
        for (int i = 0; i < CFG_REGS; i++) begin
            s[2*i]   = cfg[i][WORD_W-1:0];
            s[2*i+1] = cfg[i][CFG_W-1:WORD_W];
        end
        s[12] = ctr;
        return s;
    endfunction

endpackage

// ----- design/ccx_front.sv -----
module ccx_front #(
    parameter int QUEUE_DEPTH = ccx_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              restart,
    input  logic [31:0]       data_in,
    output logic              q_valid,
    output ccx_pkg::ccx_item_t q_item,
    input  logic              q_pop
);
    import ccx_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    ccx_item_t mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign in_stall = (count_reg == FULL_CNT);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{restart: restart, data: data_in};
        end
    end

endmodule

// ----- design/ccx_block.sv -----
module ccx_block #(
    parameter int DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ccx_pkg::ccx_cfg_t    cfg,
    input  ccx_pkg::ccx_blk_ctl_t ctl,
    output logic                 done,
    output ccx_pkg::ccx_state_t  ks
);
    import ccx_pkg::*;

    localparam int RND_W = $clog2(2 * DOUBLE_ROUNDS + 1);
    localparam logic [RND_W-1:0] LAST_RND = RND_W'(2 * DOUBLE_ROUNDS);

    ccx_state_t work_reg, work_next;
    ccx_state_t rnd_state;
    logic [WORD_W-1:0] ctr_reg, ctr_next;
    logic [RND_W-1:0]  round_reg, round_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    // four quarter-rounds side by side: even steps columns, odd steps diagonals
    always_comb
    begin
        ccx_qr_t q;
        logic [3:0] ia, ib, ic, id;
        logic diag;
        diag = round_reg[0];
        rnd_state = work_reg;
        for (int j = 0; j < 4; j++)
        begin
            ia = 4'(j);
            ib = diag ? 4'(4 + ((j + 1) & 3))  : 4'(4 + j);
            ic = diag ? 4'(8 + ((j + 2) & 3))  : 4'(8 + j);
            id = diag ? 4'(12 + ((j + 3) & 3)) : 4'(12 + j);
            q = quarter_round('{a: work_reg[ia], b: work_reg[ib],
                                c: work_reg[ic], d: work_reg[id]});
            rnd_state[ia] = q.a;
            rnd_state[ib] = q.b;
            rnd_state[ic] = q.c;
            rnd_state[id] = q.d;
        end
    end

    always_comb
    begin
        ccx_state_t init;
        work_next  = work_reg;
        ctr_next   = ctr_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        init       = build_state(cfg, ctr_reg);
        if (ctl.start)
        begin
            work_next  = build_state(cfg, ctl.ctr);
            ctr_next   = ctl.ctr;
            round_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (round_reg == LAST_RND)
            begin
                // feed-forward of the original words
                for (int i = 0; i < BLOCK_WORDS; i++)
                begin
                    work_next[i] = work_reg[i] + init[i];
                end
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                work_next  = rnd_state;
                round_next = round_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            round_reg <= round_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        ctr_reg  <= ctr_next;
    end

    assign done = done_reg;
    assign ks   = work_reg;

endmodule

// ----- design/ccx_back.sv -----
module ccx_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  ccx_pkg::ccx_item_t    q_item,
    output logic                  q_pop,
    input  logic [31:0]           cfg_ctr,
    output ccx_pkg::ccx_blk_ctl_t blk_ctl,
    input  logic                  blk_done,
    input  ccx_pkg::ccx_state_t   ks,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           data_out
);
    import ccx_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_GEN  = 1'b1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_WORDS - 1);

    logic state_reg, state_next;
    logic [WORD_W-1:0] counter_reg, counter_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic buf_valid_reg, buf_valid_next;
    logic fresh_reg, fresh_next;
    logic out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic need_block;
    logic out_free;

    // a restart already served by a fresh block must not trigger another
    assign need_block = (q_item.restart && !fresh_reg) || !buf_valid_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        pos_next       = pos_reg;
        buf_valid_next = buf_valid_reg;
        fresh_next     = fresh_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        blk_ctl.start  = 1'b0;
        blk_ctl.ctr    = counter_reg;
        q_pop          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && need_block)
                begin
                    blk_ctl.start  = 1'b1;
                    blk_ctl.ctr    = q_item.restart ? cfg_ctr : counter_reg;
                    counter_next   = blk_ctl.ctr;
                    pos_next       = '0;
                    buf_valid_next = 1'b0;
                    state_next     = ST_GEN;
                end
                else if (q_valid && out_free)
                begin
                    q_pop          = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next  = q_item.data ^ ks[pos_reg];
                    fresh_next     = 1'b0;
                    pos_next       = pos_reg + 1'b1;
                    if (pos_reg == LAST_POS)
                    begin
                        buf_valid_next = 1'b0;
                        counter_next   = counter_reg + 1'b1;
                    end
                end
            end
            ST_GEN:
            begin
                if (blk_done)
                begin
                    buf_valid_next = 1'b1;
                    fresh_next     = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            pos_reg       <= '0;
            buf_valid_reg <= 1'b0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            pos_reg       <= pos_next;
            buf_valid_reg <= buf_valid_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign data_out  = out_data_reg;

endmodule

// ----- design/chacha20_stream_xor.sv -----
// ChaCha20 stream XOR, one 32-bit little-endian word in and one word out per item.
// Eight 64-bit registers (byte address 8*i, low half is the lower-numbered state
// word) hold the constants, key, initial block counter and nonce; write them only
// while the block is idle. Input words enter a small queue, so the input side keeps
// accepting while a result waits on out_stall, until the queue is full. A keystream
// block is computed on demand by a round unit that does four quarter-rounds per
// cycle: it loads the initial state, runs DOUBLE_ROUNDS double rounds of columns and
// diagonals, adds the original words back and hands the block off. The sixteen words
// of that block then leave at one word per cycle while input words are queued and
// out_stall is low. A word with restart set reloads the block counter from the
// register and starts a new block for itself.
module chacha20_stream_xor #(
    parameter int DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF,  // 1 to 16
    parameter int QUEUE_DEPTH   = ccx_pkg::QUEUE_DEPTH_DEF     // 2 or more
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // register port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ccx_pkg::ADDR_W-1:0]  paddr,
    input  logic [ccx_pkg::CFG_W-1:0]   pwdata,
    output logic [ccx_pkg::CFG_W-1:0]   prdata,
    output logic                        pready,
    // input words
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        restart,
    input  logic [31:0]                 data_in,
    // output words
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [31:0]                 data_out
);
    import ccx_pkg::*;

    ccx_cfg_t cfg_reg;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic cfg_wr;

    logic         q_valid;
    ccx_item_t    q_item;
    logic         q_pop;
    ccx_blk_ctl_t blk_ctl;
    logic         blk_done;
    ccx_state_t   ks;

    // register file, registers sit on 8-byte boundaries
    assign cfg_idx = paddr[ADDR_W-1:ADDR_W-CFG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = cfg_reg[cfg_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr)
        begin
            cfg_reg[cfg_idx] <= pwdata;
        end
    end

    // front: input queue
    ccx_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .data_in  (data_in),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // back: sequencer, counter, word select and output register
    ccx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .cfg_ctr   (cfg_reg[CTR_REG_IDX][WORD_W-1:0]),
        .blk_ctl   (blk_ctl),
        .blk_done  (blk_done),
        .ks        (ks),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out)
    );

    // round unit, its state registers double as the keystream buffer
    ccx_block #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_block (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .ctl   (blk_ctl),
        .done  (blk_done),
        .ks    (ks)
    );

endmodule
